>>> rtl/rfalu_pkg.sv
package rfalu_pkg;

    localparam int DATA_W = 64;
    localparam int IDX_W  = 8;
    localparam int FUNC_W = 5;
    localparam int IMM_W  = 32;

    localparam logic [FUNC_W-1:0] FN_ADD  = 5'd0;
    localparam logic [FUNC_W-1:0] FN_SUB  = 5'd1;
    localparam logic [FUNC_W-1:0] FN_MUL  = 5'd2;
    localparam logic [FUNC_W-1:0] FN_DIV  = 5'd3;
    localparam logic [FUNC_W-1:0] FN_MOD  = 5'd4;
    localparam logic [FUNC_W-1:0] FN_AND  = 5'd5;
    localparam logic [FUNC_W-1:0] FN_OR   = 5'd6;
    localparam logic [FUNC_W-1:0] FN_XOR  = 5'd7;
    localparam logic [FUNC_W-1:0] FN_SHL  = 5'd8;
    localparam logic [FUNC_W-1:0] FN_SAR  = 5'd9;
    localparam logic [FUNC_W-1:0] FN_SHR  = 5'd10;
    localparam logic [FUNC_W-1:0] FN_CMP3 = 5'd11;
    localparam logic [FUNC_W-1:0] FN_CMP3B = 5'd12;
    localparam logic [FUNC_W-1:0] FN_LAND = 5'd13;
    localparam logic [FUNC_W-1:0] FN_LOR  = 5'd14;
    localparam logic [FUNC_W-1:0] FN_EQ   = 5'd15;
    localparam logic [FUNC_W-1:0] FN_NE   = 5'd16;
    localparam logic [FUNC_W-1:0] FN_LT   = 5'd17;
    localparam logic [FUNC_W-1:0] FN_GT   = 5'd18;
    localparam logic [FUNC_W-1:0] FN_LE   = 5'd19;
    localparam logic [FUNC_W-1:0] FN_GE   = 5'd20;
    localparam logic [FUNC_W-1:0] FN_ZERO = 5'd21;
    localparam logic [FUNC_W-1:0] FN_UNUSED_TOP = 5'd31;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              wide;
        logic [IDX_W-1:0]  dest;
    } op_t;

endpackage

>>> rtl/rfalu_ram.sv
module rfalu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/rfalu_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
module rfalu_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quot,
    output logic [63:0] rem
);
    import rfalu_pkg::*;

    logic [63:0] q_reg, q_next, r_reg, r_next, d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [64:0] trial;
    logic [64:0] shifted;

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done      = 1'b0;
        shifted   = {r_reg, q_reg[63]};
        trial     = shifted - {1'b0, d_reg};
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial[64]) begin
                r_next = shifted[63:0];
                q_next = {q_reg[62:0], 1'b0};
            end else begin
                r_next = trial[63:0];
                q_next = {q_reg[62:0], 1'b1};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63) begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    assign quot = q_next;
    assign rem  = r_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end
endmodule

>>> rtl/register_file_integer_alu_unit.sv
// The result register is loaded after the register read, execute and writeback/result
// steps; mul repeats the execute step, and div and mod with a nonzero divisor wait on
// a one-bit-per-cycle divider.
// One request in flight at a time; the next is accepted the cycle after the result
// is taken.
// After reset a clearing pass zeroes every register first.
module register_file_integer_alu_unit #(
    parameter int REG_COUNT = 256
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rfalu_pkg::FUNC_W-1:0] s_func,
    input  logic                        s_wide,
    input  logic                        s_use_imm,
    input  logic [rfalu_pkg::IDX_W-1:0] s_dest_index,
    input  logic [rfalu_pkg::IDX_W-1:0] s_src_a_index,
    input  logic [rfalu_pkg::IDX_W-1:0] s_src_b_index,
    input  logic signed [rfalu_pkg::IMM_W-1:0] s_imm_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rfalu_pkg::IDX_W-1:0] m_written_index,
    output logic signed [rfalu_pkg::DATA_W-1:0] m_written_value,
    output logic                        m_div_by_zero
);
    import rfalu_pkg::*;

    localparam int AW = $clog2(REG_COUNT);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;   // memory read in flight
    localparam logic [2:0] ST_EXEC  = 3'd3;   // operands valid, compute
    localparam logic [2:0] ST_DIV   = 3'd4;   // waiting on divider
    localparam logic [2:0] ST_WB    = 3'd5;   // combine with old dest, write

    logic [2:0]  st_reg, st_next;
    logic [AW:0] clr_reg, clr_next;

    // request capture
    op_t         op_reg;
    logic        use_imm_reg;
    logic [63:0] imm_reg;
    logic        a_ok_reg, b_ok_reg, d_ok_reg;
    logic [IDX_W-1:0] sa_reg, sb_reg;

    // three-port read of the file: one RAM copy per read port, same writes
    logic        we;
    logic [AW-1:0] waddr;
    logic [63:0] wdata;
    logic [63:0] ra_data, rb_data, rd_data;

    // read addresses come straight from the request in idle, so the data
    // lands at the accepting edge and is valid during ST_READ
    logic          in_idle;
    logic [AW-1:0] ra_addr, rb_addr, rd_addr;
    assign in_idle = (st_reg == ST_IDLE);
    assign ra_addr = in_idle ? AW'(s_src_a_index) : AW'(sa_reg);
    assign rb_addr = in_idle ? AW'(s_src_b_index) : AW'(sb_reg);
    assign rd_addr = in_idle ? AW'(s_dest_index)  : AW'(op_reg.dest);

    rfalu_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_ram_a (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(ra_addr), .rdata(ra_data));
    rfalu_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_ram_b (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(rb_addr), .rdata(rb_data));
    rfalu_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_ram_d (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(rd_addr), .rdata(rd_data));

    // operand regs, latched in ST_EXEC entry
    logic [63:0] a_reg, b_reg, old_reg;
    logic [63:0] a_next, b_next;
    logic [63:0] res_reg, res_next;
    logic        low_reg, low_next;
    logic        dz_reg, dz_next;
    logic        neg_q_reg, neg_r_reg;

    // result register
    logic [IDX_W-1:0] out_idx_reg;
    logic [63:0]      out_val_reg;
    logic             out_dz_reg;
    logic             out_v_reg;

    // select operands and sign-normalize them in narrow mode
    always_comb begin
        logic [63:0] av, bv;
        av = a_ok_reg ? ra_data : 64'd0;
        bv = use_imm_reg ? imm_reg : (b_ok_reg ? rb_data : 64'd0);
        if (!op_reg.wide) begin
            av = {{32{av[31]}}, av[31:0]};
            bv = {{32{bv[31]}}, bv[31:0]};
        end
        a_next = av;
        b_next = bv;
    end

    // execute on registered operands
    logic [5:0]  cnt;
    logic        lt_ab, lt_ba, eq_ab;
    logic [63:0] prod;
    logic [63:0] ma, mb;
    always_comb begin
        cnt   = op_reg.wide ? b_reg[5:0] : {1'b0, b_reg[4:0]};
        eq_ab = (a_reg == b_reg);
        lt_ab = $signed(a_reg) < $signed(b_reg);
        lt_ba = $signed(b_reg) < $signed(a_reg);
        ma    = a_reg[63] ? (64'd0 - a_reg) : a_reg;
        mb    = b_reg[63] ? (64'd0 - b_reg) : b_reg;
    end

    // 64-bit product from three registered 32x32 partial products
    logic [63:0] pp_ll_reg, pp_lh_reg, pp_hl_reg;
    assign prod = pp_ll_reg + {pp_lh_reg[31:0] + pp_hl_reg[31:0], 32'd0};

    logic        div_start, div_done;
    logic [63:0] div_q, div_r;
    rfalu_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(ma), .divisor(mb), .done(div_done), .quot(div_q), .rem(div_r));

    logic mul_phase_reg;

    always_comb begin
        res_next  = res_reg;
        low_next  = low_reg;
        dz_next   = dz_reg;
        div_start = 1'b0;
        st_next   = st_reg;
        clr_next  = clr_reg;
        we        = 1'b0;
        waddr     = AW'(op_reg.dest);
        wdata     = 64'd0;
        s_ready   = 1'b0;
        unique case (st_reg)
            ST_CLEAR: begin
                we       = 1'b1;
                waddr    = clr_reg[AW-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(REG_COUNT - 1)) st_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_ready = !out_v_reg;
                if (s_valid && !out_v_reg) st_next = ST_READ;
            end
            ST_READ: st_next = ST_EXEC;
            ST_EXEC: begin
                low_next = !op_reg.wide;
                dz_next  = 1'b0;
                st_next  = ST_WB;
                unique case (op_reg.func)
                    FN_ADD: res_next = a_reg + b_reg;
                    FN_SUB: res_next = a_reg - b_reg;
                    FN_MUL: begin
                        res_next = prod;
                        if (!mul_phase_reg) st_next = ST_EXEC;
                    end
                    FN_DIV, FN_MOD: begin
                        if (b_reg == 64'd0) begin
                            dz_next  = 1'b1;
                            res_next = 64'd0;
                        end else begin
                            div_start = 1'b1;
                            st_next   = ST_DIV;
                        end
                    end
                    FN_AND: res_next = a_reg & b_reg;
                    FN_OR:  res_next = a_reg | b_reg;
                    FN_XOR: res_next = a_reg ^ b_reg;
                    FN_SHL: res_next = a_reg << cnt;
                    FN_SAR: res_next = 64'($signed(a_reg) >>> cnt);
                    FN_SHR: res_next = (op_reg.wide ? a_reg : {32'd0, a_reg[31:0]}) >> cnt;
                    FN_CMP3, FN_CMP3B: begin
                        res_next = eq_ab ? 64'd0 : (lt_ba ? 64'd1 : 64'h0000_0000_FFFF_FFFF);
                        low_next = 1'b1;
                    end
                    FN_LAND: res_next = {63'd0, (a_reg != 64'd0) && (b_reg != 64'd0)};
                    FN_LOR:  res_next = {63'd0, (a_reg != 64'd0) || (b_reg != 64'd0)};
                    FN_EQ: begin res_next = {63'd0, eq_ab};  low_next = 1'b1; end
                    FN_NE: begin res_next = {63'd0, !eq_ab}; low_next = 1'b1; end
                    FN_LT: begin res_next = {63'd0, lt_ab};  low_next = 1'b1; end
                    FN_GT: begin res_next = {63'd0, lt_ba};  low_next = 1'b1; end
                    FN_LE: begin res_next = {63'd0, !lt_ba}; low_next = 1'b1; end
                    FN_GE: begin res_next = {63'd0, !lt_ab}; low_next = 1'b1; end
                    default: begin res_next = 64'd0; low_next = 1'b1; end
                endcase
            end
            ST_DIV: begin
                if (div_done) begin
                    res_next = (op_reg.func == FN_DIV)
                             ? (neg_q_reg ? 64'd0 - div_q : div_q)
                             : (neg_r_reg ? 64'd0 - div_r : div_r);
                    st_next  = ST_WB;
                end
            end
            ST_WB: begin
                we      = d_ok_reg;
                wdata   = low_reg ? {old_reg[63:32], res_reg[31:0]} : res_reg;
                st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_CLEAR;
            clr_reg       <= '0;
            out_v_reg     <= 1'b0;
            mul_phase_reg <= 1'b0;
        end else begin
            st_reg  <= st_next;
            clr_reg <= clr_next;
            if (st_reg == ST_EXEC && op_reg.func == FN_MUL) begin
                mul_phase_reg <= !mul_phase_reg;
            end
            if (st_reg == ST_WB) begin
                out_v_reg <= 1'b1;
            end else if (m_ready) begin
                out_v_reg <= 1'b0;
            end
        end

        if (s_valid && s_ready) begin
            op_reg.func <= s_func;
            op_reg.wide <= s_wide;
            op_reg.dest <= s_dest_index;
            use_imm_reg <= s_use_imm;
            imm_reg     <= {{32{s_imm_value[31]}}, s_imm_value};
            sa_reg      <= s_src_a_index;
            sb_reg      <= s_src_b_index;
            a_ok_reg    <= 32'(s_src_a_index) < 32'(REG_COUNT);
            b_ok_reg    <= 32'(s_src_b_index) < 32'(REG_COUNT);
            d_ok_reg    <= 32'(s_dest_index) < 32'(REG_COUNT);
        end
        if (st_reg == ST_READ) begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            old_reg <= d_ok_reg ? rd_data : 64'd0;
        end
        if (st_reg == ST_EXEC) begin
            neg_q_reg <= a_reg[63] ^ b_reg[63];
            neg_r_reg <= a_reg[63];
        end
        pp_ll_reg <= 64'(a_reg[31:0]) * 64'(b_reg[31:0]);
        pp_lh_reg <= 64'(a_reg[31:0]) * 64'(b_reg[63:32]);
        pp_hl_reg <= 64'(a_reg[63:32]) * 64'(b_reg[31:0]);
        res_reg <= res_next;
        low_reg <= low_next;
        dz_reg  <= dz_next;
        if (st_reg == ST_WB) begin
            out_idx_reg <= op_reg.dest;
            out_val_reg <= low_reg ? {old_reg[63:32], res_reg[31:0]} : res_reg;
            out_dz_reg  <= dz_reg;
        end
    end

    assign m_valid         = out_v_reg;
    assign m_written_index = out_idx_reg;
    assign m_written_value = out_val_reg;
    assign m_div_by_zero   = out_dz_reg;
endmodule
